// ===== sv/rrqs_pkg.sv =====
package rrqs_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int IDX_W       = $clog2(NUM_SLOTS);
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = CFG_IDX_W'(1);
    localparam logic [7:0]           QUANTUM_RESET = 8'd10;
    localparam logic [31:0]          TICKS_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_YIELD = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_YIELD = 2'd1,
        OP_WRITE = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] slot;
        status_t          status;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  slice;
        logic [31:0] ticks;
    } row_t;

    typedef struct packed {
        logic [7:0] quantum;
        logic       enabled;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  slice_left;
        logic [31:0] current_ticks;
        logic        switched;
        logic        current_valid;
        logic [3:0]  current_slot;
    } result_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(NUM_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== sv/rrqs_front.sv =====
module rrqs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // Fields from bit 0: slot[3:0], new_status[5:4], zero fill[7:6].
    input  logic [7:0]         s_axis_tdata,
    // Fields from bit 0: command[1:0].
    input  logic [1:0]         s_axis_tuser,
    output logic               push_valid,
    input  logic               push_ready,
    output rrqs_pkg::cmd_t     push_data
);
    import rrqs_pkg::*;

    logic                 in_valid_reg;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    logic [IDX_W+3:0]     slot_ext;
    logic                 slot_in_range;
    logic                 accept;

    assign slot_ext      = {{IDX_W{1'b0}}, s_axis_tdata[3:0]};
    assign slot_in_range = slot_ext < (IDX_W + 4)'(NUM_SLOTS);
    assign s_axis_tready = !in_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd_next.slot   = slot_ext[IDX_W-1:0];
        cmd_next.status = status_t'(s_axis_tdata[5:4]);
        unique case (s_axis_tuser)
            CMD_TICK:  cmd_next.op = OP_TICK;
            CMD_YIELD: cmd_next.op = OP_YIELD;
            CMD_WRITE: cmd_next.op = slot_in_range ? OP_WRITE : OP_NOP;
            default:   cmd_next.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign push_valid = in_valid_reg;
    assign push_data  = cmd_reg;

endmodule

// ===== sv/rrqs_queue.sv =====
module rrqs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rrqs_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rrqs_pkg::cmd_t pop_data
);
    import rrqs_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/rrqs_back.sv =====
module rrqs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rrqs_pkg::cfg_t    cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  rrqs_pkg::cmd_t    pop_data,
    output logic              res_valid,
    input  logic              res_ready,
    output rrqs_pkg::result_t res_data
);
    import rrqs_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_TICK_RD   = 11'b000_0000_0010,
        S_TICK_UPD  = 11'b000_0000_0100,
        S_YLD_RD    = 11'b000_0000_1000,
        S_YLD_FIX   = 11'b000_0001_0000,
        S_WR_RD     = 11'b000_0010_0000,
        S_WR_UPD    = 11'b000_0100_0000,
        S_SCAN_INIT = 11'b000_1000_0000,
        S_SCAN      = 11'b001_0000_0000,
        S_COMMIT    = 11'b010_0000_0000,
        S_REP       = 11'b100_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             present_reg, present_next;
    logic [IDX_W-1:0] old_cur_reg, old_cur_next;
    logic             old_present_reg, old_present_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_addr_reg, chk_addr_next;
    logic             chk_last_reg, chk_last_next;
    row_t             slot0_row_reg, slot0_row_next;
    row_t             pick_row_reg, pick_row_next;
    logic [IDX_W-1:0] pick_idx_reg, pick_idx_next;
    logic             rep_wait_reg, rep_wait_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    row_t             row_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] row_vld_reg;
    row_t             rd_row_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    row_t             wr_row;
    row_t             eff_row;
    row_t             upd_row;
    row_t             fb_row;
    logic [IDX_W+3:0] cur_ext;

    assign eff_row   = rd_vld_reg ? rd_row_reg : '0;
    assign cur_ext   = {4'b0, cur_reg};
    assign pop_ready = state_reg == S_IDLE;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= row_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= row_vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        cur_next         = cur_reg;
        present_next     = present_reg;
        old_cur_next     = old_cur_reg;
        old_present_next = old_present_reg;
        k_next           = k_reg;
        iss_next         = iss_reg;
        chk_vld_next     = 1'b0;
        chk_addr_next    = chk_addr_reg;
        chk_last_next    = chk_last_reg;
        slot0_row_next   = slot0_row_reg;
        pick_row_next    = pick_row_reg;
        pick_idx_next    = pick_idx_reg;
        rep_wait_next    = rep_wait_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !res_ready;
        rd_addr          = cur_reg;
        wr_en            = 1'b0;
        wr_addr          = cur_reg;
        wr_row           = eff_row;
        upd_row          = eff_row;
        fb_row           = slot0_row_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next         = pop_data;
                    old_cur_next     = cur_reg;
                    old_present_next = present_reg;
                    unique case (pop_data.op)
                        OP_TICK:
                            state_next = (cfg.enabled && present_reg) ? S_TICK_RD : S_REP;
                        OP_YIELD:
                        begin
                            if (!cfg.enabled)
                            begin
                                state_next = S_REP;
                            end
                            else
                            begin
                                state_next = present_reg ? S_YLD_RD : S_SCAN_INIT;
                            end
                        end
                        OP_WRITE:
                            state_next = S_WR_RD;
                        default:
                            state_next = S_REP;
                    endcase
                    rep_wait_next = 1'b0;
                end
            end
            S_TICK_RD:
            begin
                state_next = S_TICK_UPD;
            end
            S_TICK_UPD:
            begin
                if (eff_row.ticks != TICKS_MAX)
                begin
                    upd_row.ticks = eff_row.ticks + 32'd1;
                end
                if (eff_row.slice != 8'd0)
                begin
                    upd_row.slice = eff_row.slice - 8'd1;
                end
                if (upd_row.slice == 8'd0)
                begin
                    upd_row.slice = cfg.quantum;
                    if (eff_row.status == ST_RUNNING)
                    begin
                        upd_row.status = ST_READY;
                    end
                    state_next = S_SCAN_INIT;
                end
                else
                begin
                    state_next = S_REP;
                end
                wr_en  = 1'b1;
                wr_row = upd_row;
            end
            S_YLD_RD:
            begin
                state_next = S_YLD_FIX;
            end
            S_YLD_FIX:
            begin
                if (eff_row.status == ST_RUNNING)
                begin
                    upd_row.status = ST_READY;
                end
                wr_en      = 1'b1;
                wr_row     = upd_row;
                state_next = S_SCAN_INIT;
            end
            S_WR_RD:
            begin
                rd_addr    = cmd_reg.slot;
                state_next = S_WR_UPD;
            end
            S_WR_UPD:
            begin
                if (eff_row.status == ST_EMPTY && cmd_reg.status != ST_EMPTY)
                begin
                    upd_row.slice = cfg.quantum;
                    upd_row.ticks = '0;
                end
                upd_row.status = cmd_reg.status;
                wr_en   = 1'b1;
                wr_addr = cmd_reg.slot;
                wr_row  = upd_row;
                if (cmd_reg.status == ST_EMPTY && present_reg && cur_reg == cmd_reg.slot)
                begin
                    present_next = 1'b0;
                end
                state_next = S_REP;
            end
            S_SCAN_INIT:
            begin
                k_next     = next_idx(present_reg ? cur_reg : '0);
                iss_next   = CNT_W'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                rd_addr = k_reg;
                if (iss_reg <= CNT_W'(NUM_SLOTS))
                begin
                    chk_vld_next  = 1'b1;
                    chk_addr_next = k_reg;
                    chk_last_next = iss_reg == CNT_W'(NUM_SLOTS);
                    k_next        = next_idx(k_reg);
                    iss_next      = iss_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (chk_addr_reg == '0)
                    begin
                        slot0_row_next = eff_row;
                        fb_row         = eff_row;
                    end
                    if (eff_row.status == ST_READY)
                    begin
                        pick_idx_next = chk_addr_reg;
                        pick_row_next = eff_row;
                        state_next    = S_COMMIT;
                    end
                    else if (chk_last_reg)
                    begin
                        if (fb_row.status != ST_EMPTY)
                        begin
                            pick_idx_next = '0;
                            pick_row_next = fb_row;
                            state_next    = S_COMMIT;
                        end
                        else
                        begin
                            state_next = S_REP;
                        end
                    end
                end
            end
            S_COMMIT:
            begin
                upd_row        = pick_row_reg;
                upd_row.status = ST_RUNNING;
                wr_en          = 1'b1;
                wr_addr        = pick_idx_reg;
                wr_row         = upd_row;
                cur_next       = pick_idx_reg;
                present_next   = 1'b1;
                state_next     = S_REP;
            end
            S_REP:
            begin
                // Reads the current row, then reports it when output is free.
                if (!rep_wait_reg)
                begin
                    rep_wait_next = 1'b1;
                end
                else if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    if (present_reg)
                    begin
                        out_next.current_slot  = cur_ext[3:0];
                        out_next.current_valid = 1'b1;
                        out_next.current_ticks = eff_row.ticks;
                        out_next.slice_left    = eff_row.slice;
                    end
                    else
                    begin
                        out_next.current_slot  = '0;
                        out_next.current_valid = 1'b0;
                        out_next.current_ticks = '0;
                        out_next.slice_left    = '0;
                    end
                    out_next.switched = (old_present_reg != present_reg) ||
                                        (present_reg && old_cur_reg != cur_reg);
                    rep_wait_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            present_reg   <= 1'b0;
            chk_vld_reg   <= 1'b0;
            rep_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            present_reg   <= present_next;
            chk_vld_reg   <= chk_vld_next;
            rep_wait_reg  <= rep_wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        old_cur_reg     <= old_cur_next;
        old_present_reg <= old_present_next;
        k_reg           <= k_next;
        iss_reg         <= iss_next;
        chk_addr_reg    <= chk_addr_next;
        chk_last_reg    <= chk_last_next;
        slot0_row_reg   <= slot0_row_next;
        pick_row_reg    <= pick_row_next;
        pick_idx_reg    <= pick_idx_next;
        out_reg         <= out_next;
    end

endmodule

// ===== sv/round_robin_quantum_scheduler.sv =====
// Round-robin time-slice scheduler over a table of task slots.
// Requests enter on the s_axis channel: tuser carries the command (tick, yield,
// status write) and tdata the slot and new status. One result leaves on the
// m_axis channel for every request, in order, reporting the current task.
// The cfg channel writes the quantum (index 0) and the enable bit (index 1);
// it is always ready and should be used only while the block is idle.
// A request passes an input register and a two-entry queue before the engine,
// which works on one request at a time and takes the next one from the queue
// only after it has reported the last. A request that reschedules runs a
// round-robin scan, which reads one slot per cycle from the table's single
// read port.
// Reset empties the table through per-slot valid bits at once, clears the
// current task, and loads quantum 10 with scheduling disabled.
// When the receiver stalls, the result waits in the output register, the
// engine holds its next result, and the queue and input register keep taking
// requests until they are full.
module round_robin_quantum_scheduler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: slot[3:0], new_status[5:4], zero fill[7:6].
    input  logic [7:0]                      s_axis_tdata,
    // Fields from bit 0: command[1:0].
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: current_slot[3:0], current_valid[4], switched[5],
    // current_ticks[37:6], slice_left[45:38], zero fill[47:46].
    output logic [47:0]                     m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rrqs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrqs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rrqs_pkg::*;

    cfg_t    cfg_reg;
    logic    f_valid;
    logic    f_ready;
    cmd_t    f_data;
    logic    q_valid;
    logic    q_ready;
    cmd_t    q_data;
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quantum <= QUANTUM_RESET;
            cfg_reg.enabled <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_QUANTUM: cfg_reg.quantum <= cfg_data[7:0];
                CFG_ENABLED: cfg_reg.enabled <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    rrqs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (f_valid),
        .push_ready    (f_ready),
        .push_data     (f_data)
    );

    rrqs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    rrqs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (res)
    );

    assign m_axis_tdata = {2'b00, res};

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[4]) |->
            (m_axis_tdata[3:0] == 4'd0 && m_axis_tdata[45:6] == 40'd0))
    else $error("Result without a current task carries nonzero fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !f_ready |-> q_valid)
    else $error("Queue reports full while empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && !f_ready) |=> f_valid)
    else $error("Front dropped a request while the queue was full.");

endmodule
